[rtl/core/ght_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generational handle table package
// Widths, codes and the transaction types shared by the handle table files.
// ----------------------------------------------------------------------------
package ght_pkg;

    localparam int MAX_ENTITIES = 1024;
    localparam int NUM_TYPES    = 16;
    localparam int ID_W         = $clog2(MAX_ENTITIES);
    localparam int TYPE_W       = $clog2(NUM_TYPES);
    localparam int GEN_W        = 15;
    localparam int PAY_W        = 32;
    localparam int CNT_W        = ID_W + 1;
    localparam int DENSE_AW     = TYPE_W + ID_W;
    localparam logic [GEN_W-1:0] GEN_MAX = '1;

    typedef enum logic [2:0] {
        KIND_SPAWN   = 3'd0,
        KIND_DESPAWN = 3'd1,
        KIND_QUERY   = 3'd2,
        KIND_SLOT    = 3'd3,
        KIND_WRITE   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DEAD   = 2'd1,
        ST_FULL   = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [TYPE_W-1:0] type_sel;
        logic [ID_W-1:0]   handle_id;
        logic [GEN_W-1:0]  handle_gen;
        logic [ID_W-1:0]   slot_sel;
        logic [PAY_W-1:0]  payload_in;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   out_id;
        logic [GEN_W-1:0]  out_gen;
        logic [TYPE_W-1:0] out_type;
        logic [ID_W-1:0]   out_slot;
        logic [PAY_W-1:0]  payload_out;
        logic [CNT_W-1:0]  type_count;
        logic              alive;
        logic              moved_valid;
        logic [ID_W-1:0]   moved_id;
    } rsp_t;

    // Step commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic rd0;
        logic rd1;
        logic rd2;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic kind_ok;
    } stat_t;

endpackage
`default_nettype wire

[rtl/core/ght_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one table operation per transaction.
// ----------------------------------------------------------------------------
interface ght_req_if;
    import ght_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/ght_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one operation result per transaction.
// ----------------------------------------------------------------------------
interface ght_rsp_if;
    import ght_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/ght_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Handle table controller
// Steps each operation through three read phases and a commit phase.
// ----------------------------------------------------------------------------
module ght_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire ght_pkg::stat_t stat,
    output ght_pkg::cmd_t      cmd
);
    import ght_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RD0    = 5'b00010,
        S_RD1    = 5'b00100,
        S_RD2    = 5'b01000,
        S_COMMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   room;

    assign room      = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                cmd.rd0    = 1'b1;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.rd1    = 1'b1;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.rd2    = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // Unknown kinds finish here without a result.
                if (!stat.kind_ok)
                begin
                    state_next = S_IDLE;
                end
                else if (room)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("controller state is not one-hot");
    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == S_RD0))
        else $error("accepted transaction did not start the read phases");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("pending response dropped");
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");
endmodule
`default_nettype wire

[rtl/core/ght_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Handle table datapath
// Slot table, free id stack, dense arrays and counters with the result register.
// ----------------------------------------------------------------------------
module ght_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ght_pkg::req_t req,
    input  wire ght_pkg::cmd_t cmd,
    output ght_pkg::stat_t     stat,
    output ght_pkg::rsp_t      rsp
);
    import ght_pkg::*;

    typedef struct packed {
        logic              live;
        logic [GEN_W-1:0]  gen;
        logic [TYPE_W-1:0] typ;
    } meta_t;

    // Memories.
    meta_t             meta_mem  [MAX_ENTITIES];
    logic [ID_W-1:0]   pos_mem   [MAX_ENTITIES];
    logic [ID_W-1:0]   stack_mem [MAX_ENTITIES];
    logic [ID_W-1:0]   owner_mem [MAX_ENTITIES*NUM_TYPES];
    logic [PAY_W-1:0]  pay_mem   [MAX_ENTITIES*NUM_TYPES];

    meta_t             meta_q;
    logic [ID_W-1:0]   pos_q, stack_q, owner_q;
    logic [PAY_W-1:0]  pay_q;

    // Counters.
    logic [CNT_W-1:0]  fresh_reg, top_reg;
    logic [CNT_W-1:0]  cnt_reg [NUM_TYPES];

    // Latched request and working values.
    req_t              req_reg;
    logic [ID_W-1:0]   id_reg, wpos_reg, mover_reg;
    logic [GEN_W-1:0]  gen_reg;
    logic [TYPE_W-1:0] wt_reg;
    logic              live_reg, stk_reg;
    logic [PAY_W-1:0]  pay_reg;
    rsp_t              rsp_reg, rsp_next;

    kind_t             kind;
    logic [ID_W-1:0]   spawn_id;
    logic [CNT_W-1:0]  cnt_rd1, cnt_wt, cnt_t;
    logic [ID_W-1:0]   last_rd1, last_wt;

    // Read port controls.
    logic              meta_re, owner_re, pay_re;
    logic [ID_W-1:0]   meta_ra;
    logic [DENSE_AW-1:0] owner_ra, pay_ra;

    // Write port controls.
    logic              meta_we, pos_we, stack_we, owner_we, pay_we, cnt_we;
    meta_t             meta_wd;
    logic [ID_W-1:0]   meta_wa, pos_wa, pos_wd, owner_wd;
    logic [DENSE_AW-1:0] owner_wa, pay_wa;
    logic [PAY_W-1:0]  pay_wd;
    logic [TYPE_W-1:0] cnt_wi;
    logic [CNT_W-1:0]  cnt_wd, fresh_next, top_next;

    logic              alive, full;
    logic [GEN_W-1:0]  gen_new;

    assign kind         = kind_t'(req_reg.kind);
    assign stat.kind_ok = (req_reg.kind <= KIND_WRITE);
    assign spawn_id     = (top_reg != '0) ? stack_q : fresh_reg[ID_W-1:0];
    assign cnt_rd1      = cnt_reg[meta_q.typ];
    assign last_rd1     = ID_W'(cnt_rd1 - CNT_W'(1));
    assign cnt_wt       = cnt_reg[wt_reg];
    assign last_wt      = ID_W'(cnt_wt - CNT_W'(1));
    assign cnt_t        = cnt_reg[req_reg.type_sel];
    assign alive        = live_reg && (gen_reg == req_reg.handle_gen) &&
                          ({1'b0, req_reg.handle_id} < fresh_reg);
    assign full         = ((top_reg == '0) && (fresh_reg >= CNT_W'(MAX_ENTITIES))) ||
                          (cnt_t >= CNT_W'(MAX_ENTITIES));
    assign gen_new      = (gen_reg == GEN_MAX) ? GEN_W'(1) : gen_reg + GEN_W'(1);
    assign rsp          = rsp_reg;

    always_comb
    begin
        meta_re  = cmd.rd0 || cmd.rd1;
        meta_ra  = req_reg.handle_id;
        if (cmd.rd1)
        begin
            meta_ra = (kind == KIND_SLOT) ? owner_q : spawn_id;
        end
        owner_re = cmd.rd0 || cmd.rd1;
        owner_ra = cmd.rd0 ? {req_reg.type_sel, req_reg.slot_sel} : {meta_q.typ, last_rd1};
        pay_re   = cmd.rd0 || cmd.rd1 || cmd.rd2;
        pay_ra   = {req_reg.type_sel, req_reg.slot_sel};
        if (cmd.rd1)
        begin
            pay_ra = {meta_q.typ, pos_q};
        end
        else if (cmd.rd2)
        begin
            pay_ra = {wt_reg, last_wt};
        end
    end

    always_comb
    begin
        meta_we    = 1'b0;
        meta_wa    = id_reg;
        meta_wd    = '{live: 1'b1, gen: gen_new, typ: req_reg.type_sel};
        pos_we     = 1'b0;
        pos_wa     = id_reg;
        pos_wd     = cnt_t[ID_W-1:0];
        stack_we   = 1'b0;
        owner_we   = 1'b0;
        owner_wa   = {req_reg.type_sel, cnt_t[ID_W-1:0]};
        owner_wd   = id_reg;
        pay_we     = 1'b0;
        pay_wa     = {req_reg.type_sel, cnt_t[ID_W-1:0]};
        pay_wd     = req_reg.payload_in;
        cnt_we     = 1'b0;
        cnt_wi     = req_reg.type_sel;
        cnt_wd     = cnt_t + CNT_W'(1);
        fresh_next = fresh_reg;
        top_next   = top_reg;
        rsp_next   = '0;

        case (kind)
            KIND_SPAWN:
            begin
                if (full)
                begin
                    rsp_next.status     = ST_FULL;
                    rsp_next.type_count = cnt_t;
                end
                else
                begin
                    meta_we  = 1'b1;
                    pos_we   = 1'b1;
                    owner_we = 1'b1;
                    pay_we   = 1'b1;
                    cnt_we   = 1'b1;
                    if (stk_reg)
                    begin
                        top_next = top_reg - CNT_W'(1);
                    end
                    else
                    begin
                        fresh_next = fresh_reg + CNT_W'(1);
                    end
                    rsp_next.out_id      = id_reg;
                    rsp_next.out_gen     = gen_new;
                    rsp_next.out_type    = req_reg.type_sel;
                    rsp_next.out_slot    = cnt_t[ID_W-1:0];
                    rsp_next.payload_out = req_reg.payload_in;
                    rsp_next.type_count  = cnt_t + CNT_W'(1);
                    rsp_next.alive       = 1'b1;
                end
            end
            KIND_DESPAWN:
            begin
                if (!alive)
                begin
                    rsp_next.status  = ST_DEAD;
                    rsp_next.out_id  = req_reg.handle_id;
                    rsp_next.out_gen = req_reg.handle_gen;
                end
                else
                begin
                    meta_we = 1'b1;
                    meta_wd = '{live: 1'b0, gen: gen_reg, typ: wt_reg};
                    rsp_next.out_id      = id_reg;
                    rsp_next.out_gen     = gen_reg;
                    rsp_next.out_type    = wt_reg;
                    rsp_next.out_slot    = wpos_reg;
                    rsp_next.payload_out = pay_reg;
                    rsp_next.alive       = 1'b1;
                    rsp_next.type_count  = cnt_wt;
                    if (cnt_wt != '0)
                    begin
                        cnt_we = 1'b1;
                        cnt_wi = wt_reg;
                        cnt_wd = cnt_wt - CNT_W'(1);
                        rsp_next.type_count = cnt_wt - CNT_W'(1);
                        // Swap the last entry into the hole.
                        if (wpos_reg < last_wt)
                        begin
                            owner_we = 1'b1;
                            owner_wa = {wt_reg, wpos_reg};
                            owner_wd = mover_reg;
                            pay_we   = 1'b1;
                            pay_wa   = {wt_reg, wpos_reg};
                            pay_wd   = pay_q;
                            pos_we   = 1'b1;
                            pos_wa   = mover_reg;
                            pos_wd   = wpos_reg;
                            rsp_next.moved_valid = 1'b1;
                            rsp_next.moved_id    = mover_reg;
                        end
                    end
                    if (top_reg < CNT_W'(MAX_ENTITIES))
                    begin
                        stack_we = 1'b1;
                        top_next = top_reg + CNT_W'(1);
                    end
                end
            end
            KIND_QUERY, KIND_WRITE:
            begin
                if (!alive)
                begin
                    rsp_next.status  = ST_DEAD;
                    rsp_next.out_id  = req_reg.handle_id;
                    rsp_next.out_gen = req_reg.handle_gen;
                end
                else
                begin
                    rsp_next.out_id      = id_reg;
                    rsp_next.out_gen     = gen_reg;
                    rsp_next.out_type    = wt_reg;
                    rsp_next.out_slot    = wpos_reg;
                    rsp_next.payload_out = pay_reg;
                    rsp_next.type_count  = cnt_wt;
                    rsp_next.alive       = 1'b1;
                    if (kind == KIND_WRITE)
                    begin
                        pay_we = 1'b1;
                        pay_wa = {wt_reg, wpos_reg};
                        rsp_next.payload_out = req_reg.payload_in;
                    end
                end
            end
            KIND_SLOT:
            begin
                rsp_next.type_count = cnt_t;
                if ({1'b0, req_reg.slot_sel} >= cnt_t)
                begin
                    rsp_next.status = ST_RANGE;
                end
                else
                begin
                    rsp_next.out_id      = id_reg;
                    rsp_next.out_gen     = gen_reg;
                    rsp_next.out_type    = req_reg.type_sel;
                    rsp_next.out_slot    = req_reg.slot_sel;
                    rsp_next.payload_out = pay_reg;
                    rsp_next.alive       = 1'b1;
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    // Memory ports.
    always_ff @(posedge clk)
    begin
        if (meta_re)
        begin
            meta_q <= meta_mem[meta_ra];
        end
        if (cmd.rd0)
        begin
            pos_q   <= pos_mem[req_reg.handle_id];
            stack_q <= stack_mem[ID_W'(top_reg - CNT_W'(1))];
        end
        if (owner_re)
        begin
            owner_q <= owner_mem[owner_ra];
        end
        if (pay_re)
        begin
            pay_q <= pay_mem[pay_ra];
        end
        if (cmd.commit)
        begin
            if (meta_we)
            begin
                meta_mem[meta_wa] <= meta_wd;
            end
            if (pos_we)
            begin
                pos_mem[pos_wa] <= pos_wd;
            end
            if (stack_we)
            begin
                stack_mem[top_reg[ID_W-1:0]] <= id_reg;
            end
            if (owner_we)
            begin
                owner_mem[owner_wa] <= owner_wd;
            end
            if (pay_we)
            begin
                pay_mem[pay_wa] <= pay_wd;
            end
        end
    end

    // Working registers and result.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= req;
        end
        if (cmd.rd1)
        begin
            wt_reg   <= meta_q.typ;
            gen_reg  <= meta_q.gen;
            live_reg <= meta_q.live;
            wpos_reg <= pos_q;
            if (kind == KIND_SPAWN)
            begin
                id_reg  <= spawn_id;
                stk_reg <= (top_reg != '0);
            end
            else if (kind == KIND_SLOT)
            begin
                id_reg  <= owner_q;
                pay_reg <= pay_q;
            end
            else
            begin
                id_reg <= req_reg.handle_id;
            end
        end
        if (cmd.rd2)
        begin
            if (kind == KIND_SPAWN)
            begin
                gen_reg <= stk_reg ? meta_q.gen : '0;
            end
            else if (kind == KIND_SLOT)
            begin
                gen_reg <= meta_q.gen;
            end
            else
            begin
                pay_reg   <= pay_q;
                mover_reg <= owner_q;
            end
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= '0;
            top_reg   <= '0;
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            fresh_reg <= fresh_next;
            top_reg   <= top_next;
            if (cnt_we)
            begin
                cnt_reg[cnt_wi] <= cnt_wd;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/core/generational_handle_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generational handle table
// Entity slot table with generations and per-type dense arrays.
// ----------------------------------------------------------------------------
// Each request transaction is one operation: spawn, despawn, handle query,
// dense slot read or payload write. Every operation runs from acceptance to
// its result in three read phases and one commit phase, set by the chain of
// dependent single-port memory reads that a despawn needs (slot entry, then
// last owner and payload at two dense positions). One operation is in flight
// at a time; the result waits in an output register, and the next request is
// accepted in the cycle after the previous one is committed, even if its
// response transaction has not yet been taken, so the block never takes a new
// operation before it is through with the last one. A commit waits while an
// earlier result is still untaken. Request kinds 5 to 7 are accepted, pass
// through the same phases and are dropped without a response. No clearing
// pass is needed after reset: only the fresh id count, free stack top and
// per-type counts reset.
module generational_handle_table (
    input wire logic clk,
    input wire logic rst_n,
    ght_req_if.sink  req,
    ght_rsp_if.source rsp
);
    import ght_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // The controller sequences the phases and owns the handshakes.
    ght_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds all storage and builds the result.
    ght_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.data),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp.data)
    );
endmodule
`default_nettype wire

[sim/generational_handle_table_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle table test
// Drives table operations through the request channel, predicts every result
// with an in-bench model of the slot table, free stack and dense arrays, and
// compares each response transaction field by field under varied back-pressure.
// ----------------------------------------------------------------------------
module generational_handle_table_test;
    import ght_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 20;

    logic clk;
    logic rst_n;

    ght_req_if req ();
    ght_rsp_if rsp ();

    generational_handle_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Shadow copy of the table contents. Generations are held as a magnitude
    // plus a separate live flag, as the block keeps them.
    logic [GEN_W-1:0]  gen_mag   [MAX_ENTITIES];
    bit                is_live   [MAX_ENTITIES];
    logic [TYPE_W-1:0] ent_type  [MAX_ENTITIES];
    logic [ID_W-1:0]   ent_pos   [MAX_ENTITIES];
    logic [ID_W-1:0]   free_ids  [MAX_ENTITIES];
    logic [ID_W-1:0]   dense_id  [NUM_TYPES][MAX_ENTITIES];
    logic [PAY_W-1:0]  dense_val [NUM_TYPES][MAX_ENTITIES];
    int                type_cnt  [NUM_TYPES];
    int                fresh_ids;
    int                free_top;

    // Results still owed by the block, oldest first.
    rsp_t pending_rsp[$];

    int errors;
    int quiet_cycles;
    int idle_pct;
    int stall_pct;
    int hold_requests;
    int hold_served;
    int hold_left;

    // One directed row: the operation and, where it is obvious, its result.
    typedef struct {
        req_t r;
        bit   typed;
        rsp_t e;
    } row_t;

    row_t rows[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Every block input is at a known value from time zero.
    initial
    begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        rsp.ready = 1'b0;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Works out the result of one accepted operation and updates the shadow
    // table. Returns 0 for the undefined kinds, which give no response.
    function automatic bit predict_result(input req_t r, output rsp_t o);
        int id;
        int t;
        int p;
        int last;
        int mover;
        bit ok;
        o = '0;
        if (r.kind > KIND_WRITE)
            return 1'b0;
        ok = (r.handle_id < fresh_ids) && is_live[r.handle_id] &&
             (gen_mag[r.handle_id] == r.handle_gen);
        case (r.kind)
            KIND_SPAWN:
            begin
                t = r.type_sel;
                if ((free_top == 0 && fresh_ids >= MAX_ENTITIES) ||
                    type_cnt[t] >= MAX_ENTITIES)
                begin
                    o.status = ST_FULL;
                    o.type_count = CNT_W'(type_cnt[t]);
                end
                else
                begin
                    if (free_top > 0)
                    begin
                        free_top--;
                        id = free_ids[free_top];
                    end
                    else
                    begin
                        id = fresh_ids;
                        fresh_ids++;
                    end
                    // The generation wraps back to one, never to zero.
                    gen_mag[id] = (gen_mag[id] == GEN_MAX) ? GEN_W'(1) :
                                  gen_mag[id] + GEN_W'(1);
                    is_live[id] = 1'b1;
                    ent_type[id] = TYPE_W'(t);
                    p = type_cnt[t];
                    ent_pos[id] = ID_W'(p);
                    dense_id[t][p] = ID_W'(id);
                    dense_val[t][p] = r.payload_in;
                    type_cnt[t] = p + 1;
                    o = entity_fields(id);
                end
            end
            KIND_DESPAWN:
            begin
                if (!ok)
                begin
                    o.status = ST_DEAD;
                    o.out_id = r.handle_id;
                    o.out_gen = r.handle_gen;
                end
                else
                begin
                    id = r.handle_id;
                    t = ent_type[id];
                    p = ent_pos[id];
                    o = entity_fields(id);
                    is_live[id] = 1'b0;
                    if (type_cnt[t] > 0)
                    begin
                        last = type_cnt[t] - 1;
                        // Swap-remove: the last entry fills the hole.
                        if (p < last)
                        begin
                            mover = dense_id[t][last];
                            dense_id[t][p] = ID_W'(mover);
                            dense_val[t][p] = dense_val[t][last];
                            ent_pos[mover] = ID_W'(p);
                            o.moved_valid = 1'b1;
                            o.moved_id = ID_W'(mover);
                        end
                        type_cnt[t] = last;
                    end
                    o.type_count = CNT_W'(type_cnt[t]);
                    if (free_top < MAX_ENTITIES)
                    begin
                        free_ids[free_top] = ID_W'(id);
                        free_top++;
                    end
                end
            end
            KIND_QUERY, KIND_WRITE:
            begin
                if (!ok)
                begin
                    o.status = ST_DEAD;
                    o.out_id = r.handle_id;
                    o.out_gen = r.handle_gen;
                end
                else
                begin
                    if (r.kind == KIND_WRITE)
                        dense_val[ent_type[r.handle_id]][ent_pos[r.handle_id]] = r.payload_in;
                    o = entity_fields(r.handle_id);
                end
            end
            default:
            begin
                t = r.type_sel;
                if (r.slot_sel >= type_cnt[t])
                begin
                    o.status = ST_RANGE;
                    o.type_count = CNT_W'(type_cnt[t]);
                end
                else
                begin
                    o = entity_fields(dense_id[t][r.slot_sel]);
                    o.out_type = TYPE_W'(t);
                    o.out_slot = r.slot_sel;
                    o.payload_out = dense_val[t][r.slot_sel];
                end
            end
        endcase
        return 1'b1;
    endfunction

    function automatic rsp_t entity_fields(input int id);
        rsp_t o;
        o = '0;
        o.status = ST_OK;
        o.out_id = ID_W'(id);
        o.out_gen = gen_mag[id];
        o.out_type = ent_type[id];
        o.out_slot = ent_pos[id];
        o.payload_out = dense_val[ent_type[id]][ent_pos[id]];
        o.type_count = CNT_W'(type_cnt[ent_type[id]]);
        o.alive = 1'b1;
        return o;
    endfunction

    // Offers one operation, with random idle cycles in front of it, and
    // returns once the block has taken the transaction. valid stays high
    // between back-to-back operations.
    task automatic issue(input req_t r, input bit typed, input rsp_t want);
        rsp_t got;
        while ($urandom_range(99) < idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data <= r;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (predict_result(r, got))
            pending_rsp.push_back(typed ? want : got);
    endtask

    task automatic send(input req_t r);
        issue(r, 1'b0, '0);
    endtask

    function automatic req_t make_req(input kind_t k, input int t, input int id,
                                      input int g, input int s, input logic [31:0] p);
        req_t r;
        r.kind = k;
        r.type_sel = TYPE_W'(t);
        r.handle_id = ID_W'(id);
        r.handle_gen = GEN_W'(g);
        r.slot_sel = ID_W'(s);
        r.payload_in = p;
        return r;
    endfunction

    function automatic rsp_t make_rsp(input status_t st, input int id, input int g,
                                      input int t, input int s, input logic [31:0] p,
                                      input int c, input bit a, input bit mv, input int mid);
        rsp_t o;
        o.status = st;
        o.out_id = ID_W'(id);
        o.out_gen = GEN_W'(g);
        o.out_type = TYPE_W'(t);
        o.out_slot = ID_W'(s);
        o.payload_out = p;
        o.type_count = CNT_W'(c);
        o.alive = a;
        o.moved_valid = mv;
        o.moved_id = ID_W'(mid);
        return o;
    endfunction

    function automatic void add_row(input req_t r, input bit typed, input rsp_t e);
        row_t w;
        w.r = r;
        w.typed = typed;
        w.e = e;
        rows.push_back(w);
    endfunction

    // A random operation. Most handles are taken from ids the table has
    // handed out, with the right generation most of the time, so that
    // despawn, query and write get past the liveness check.
    function automatic req_t random_op();
        req_t r;
        int pick;
        int id;
        r.payload_in = $urandom;
        r.type_sel = TYPE_W'($urandom_range(NUM_TYPES - 1));
        r.handle_gen = GEN_W'($urandom);
        r.handle_id = ID_W'($urandom);
        r.slot_sel = ID_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 32)
            r.kind = KIND_SPAWN;
        else if (pick < 57)
            r.kind = KIND_DESPAWN;
        else if (pick < 72)
            r.kind = KIND_QUERY;
        else if (pick < 84)
            r.kind = KIND_SLOT;
        else if (pick < 96)
            r.kind = KIND_WRITE;
        else
            r.kind = 3'($urandom_range(5, 7));
        if (fresh_ids > 0 && $urandom_range(9) > 0)
        begin
            id = $urandom_range(fresh_ids - 1);
            r.handle_id = ID_W'(id);
            if ($urandom_range(9) > 1)
                r.handle_gen = gen_mag[id];
        end
        if (r.kind == KIND_SLOT && $urandom_range(9) > 1)
            r.slot_sel = ID_W'($urandom_range(type_cnt[r.type_sel] + 1));
        return r;
    endfunction

    // Receiver side: random stalls, plus the long hold-offs that the driver
    // asks for, counted here.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            rsp.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served < hold_requests)
        begin
            rsp.ready <= 1'b0;
            hold_left <= 300;
            hold_served <= hold_served + 1;
        end
        else
            rsp.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Response checker.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_rsp.size() == 0)
                report("unexpected transaction", 1, 0);
            else
            begin
                rsp_t want;
                rsp_t got;
                want = pending_rsp.pop_front();
                got = rsp.data;
                if (got.status !== want.status) report("status", got.status, want.status);
                if (got.out_id !== want.out_id) report("out_id", got.out_id, want.out_id);
                if (got.out_gen !== want.out_gen) report("out_gen", got.out_gen, want.out_gen);
                if (got.out_type !== want.out_type)
                    report("out_type", got.out_type, want.out_type);
                if (got.out_slot !== want.out_slot)
                    report("out_slot", got.out_slot, want.out_slot);
                if (got.payload_out !== want.payload_out)
                    report("payload_out", got.payload_out, want.payload_out);
                if (got.type_count !== want.type_count)
                    report("type_count", got.type_count, want.type_count);
                if (got.alive !== want.alive) report("alive", got.alive, want.alive);
                if (got.moved_valid !== want.moved_valid)
                    report("moved_valid", got.moved_valid, want.moved_valid);
                if (got.moved_id !== want.moved_id)
                    report("moved_id", got.moved_id, want.moved_id);
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        rsp_t none;
        errors = 0;
        quiet_cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_requests = 0;
        hold_served = 0;
        hold_left = 0;
        fresh_ids = 0;
        free_top = 0;
        none = '0;
        for (int i = 0; i < MAX_ENTITIES; i++)
        begin
            gen_mag[i] = '0;
            is_live[i] = 1'b0;
            ent_type[i] = '0;
            ent_pos[i] = '0;
        end
        for (int t = 0; t < NUM_TYPES; t++)
            type_cnt[t] = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, extremes of the fields, each operation,
        // the swap on despawn, slot reads past the end, dead handles and the
        // kinds that are dropped.
        add_row(make_req(KIND_QUERY, 0, 0, 0, 0, 0), 1,
                make_rsp(ST_DEAD, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(make_req(KIND_SPAWN, 0, 1023, 32767, 1023, 32'hFFFF_FFFF), 1,
                make_rsp(ST_OK, 0, 1, 0, 0, 32'hFFFF_FFFF, 1, 1, 0, 0));
        add_row(make_req(KIND_SPAWN, 15, 0, 0, 0, 32'h0), 1,
                make_rsp(ST_OK, 1, 1, 15, 0, 32'h0, 1, 1, 0, 0));
        add_row(make_req(KIND_SPAWN, 0, 0, 0, 0, 32'h1), 1,
                make_rsp(ST_OK, 2, 1, 0, 1, 32'h1, 2, 1, 0, 0));
        add_row(make_req(KIND_DESPAWN, 0, 0, 1, 0, 0), 1,
                make_rsp(ST_OK, 0, 1, 0, 0, 32'hFFFF_FFFF, 1, 1, 1, 2));
        add_row(make_req(KIND_SLOT, 0, 0, 0, 1, 0), 1,
                make_rsp(ST_RANGE, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        add_row(make_req(KIND_SLOT, 0, 0, 0, 0, 0), 1,
                make_rsp(ST_OK, 2, 1, 0, 0, 32'h1, 1, 1, 0, 0));
        add_row(make_req(KIND_WRITE, 0, 2, 1, 0, 32'hA5A5_A5A5), 1,
                make_rsp(ST_OK, 2, 1, 0, 0, 32'hA5A5_A5A5, 1, 1, 0, 0));
        add_row(make_req(KIND_QUERY, 0, 1, 32767, 0, 0), 1,
                make_rsp(ST_DEAD, 1, 32767, 0, 0, 0, 0, 0, 0, 0));
        add_row(make_req(KIND_DESPAWN, 0, 0, 1, 0, 0), 1,
                make_rsp(ST_DEAD, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        add_row(make_req(KIND_WRITE, 0, 0, 1, 0, 32'h5A5A_5A5A), 1,
                make_rsp(ST_DEAD, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        add_row(make_req(KIND_SPAWN, 3, 0, 0, 0, 32'h1234_5678), 1,
                make_rsp(ST_OK, 0, 2, 3, 0, 32'h1234_5678, 1, 1, 0, 0));
        add_row(make_req(KIND_SLOT, 15, 0, 0, 1023, 0), 1,
                make_rsp(ST_RANGE, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        add_row(make_req(kind_t'(3'd5), 15, 1023, 32767, 1023, 32'hFFFF_FFFF), 0, none);
        add_row(make_req(kind_t'(3'd7), 0, 0, 0, 0, 0), 0, none);
        add_row(make_req(KIND_QUERY, 0, 1023, 0, 0, 0), 1,
                make_rsp(ST_DEAD, 1023, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(make_req(KIND_QUERY, 0, 0, 2, 0, 0), 0, none);
        add_row(make_req(KIND_DESPAWN, 0, 1, 1, 0, 0), 0, none);
        add_row(make_req(KIND_DESPAWN, 0, 2, 1, 0, 0), 0, none);
        foreach (rows[i])
            issue(rows[i].r, rows[i].typed, rows[i].e);

        // Random part in four idling modes. In the first mode the receiver
        // also holds off for a long stretch while operations keep coming, so
        // the output register fills and the request channel stalls.
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 81 : 29) : 0;
            stall_pct = (phase == 2) ? 81 : ((phase == 3) ? 29 : 0);
            if (phase == 0)
                hold_requests++;
            for (int n = 0; n < 275; n++)
                send(random_op());
        end
        req.valid <= 1'b0;

        while (pending_rsp.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
